FILE: rtl/date_add_days_unit_defines.svh
// ----------------------------------------------------------------------------
// date_add_days_unit_defines.svh
// Assertion macros for the date adder; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef DATE_ADD_DAYS_UNIT_DEFINES_SVH
`define DATE_ADD_DAYS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DAD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define DAD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DAD_ASSERT_IMP(lbl, ante, cons, msg)
`define DAD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Widths, calendar constants, status codes and shared types of the date adder.
// ----------------------------------------------------------------------------
package dad_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int OFFSET_W = 17;
	localparam int STATUS_W = 2;
	localparam int DACC_W   = 18;

	localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd9999;
	localparam logic [MONTH_W-1:0] M_JAN    = 4'd1;
	localparam logic [MONTH_W-1:0] M_FEB    = 4'd2;
	localparam logic [MONTH_W-1:0] M_DEC    = 4'd12;
	localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;

	localparam logic [DAY_W-1:0] MONTH_DAYS [13] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// year / 100 as (year * RECIP_100) >> RECIP_SHIFT, exact for 14-bit years
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam int CENT_W      = 8;
	localparam int REM_W       = 7;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam logic [REM_W-1:0]   REM_LAST  = 7'd99;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

	typedef struct packed {
		logic load;
		logic div;
		logic mod;
		logic inc;
		logic dec;
	} yr_cmd_t;

	typedef struct packed {
		logic               done;
		logic               range_err;
		logic               yr_inc;
		logic               yr_dec;
		logic [MONTH_W-1:0] month_next;
		logic [DACC_W-1:0]  day_next;
	} step_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		if (m == '0 || m > M_DEC) begin
			len = '0;
		end else if (m == M_FEB && leap) begin
			len = FEB_LEAP_DAYS;
		end else begin
			len = MONTH_DAYS[m];
		end
		return len;
	endfunction

endpackage

FILE: rtl/dad_req_if.sv
// ----------------------------------------------------------------------------
// dad_req_if
// Request channel: start date and day offset with valid/ready.
// ----------------------------------------------------------------------------
interface dad_req_if;
	import dad_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [YEAR_W-1:0]          year_in;
	logic [MONTH_W-1:0]         month_in;
	logic [DAY_W-1:0]           day_in;
	logic signed [OFFSET_W-1:0] offset_days;

	modport source (output valid, output year_in, output month_in, output day_in,
		output offset_days, input ready);
	modport sink (input valid, input year_in, input month_in, input day_in,
		input offset_days, output ready);
endinterface

FILE: rtl/dad_rsp_if.sv
// ----------------------------------------------------------------------------
// dad_rsp_if
// Response channel: resulting date and status with valid/ready.
// ----------------------------------------------------------------------------
interface dad_rsp_if;
	import dad_pkg::*;

	logic                valid;
	logic                ready;
	logic [YEAR_W-1:0]   year_out;
	logic [MONTH_W-1:0]  month_out;
	logic [DAY_W-1:0]    day_out;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output year_out, output month_out, output day_out,
		output status, input ready);
	modport sink (input valid, input year_out, input month_out, input day_out,
		input status, output ready);
endinterface

FILE: rtl/dad_year_tracker.sv
// ----------------------------------------------------------------------------
// dad_year_tracker
// Working year with its residue mod 100 and century count mod 4; gives the
// leap flag each cycle without a divider.
// ----------------------------------------------------------------------------
module dad_year_tracker (
	input  logic                        clk,
	input  dad_pkg::yr_cmd_t            cmd,
	input  logic [dad_pkg::YEAR_W-1:0]  year_load,
	output logic [dad_pkg::YEAR_W-1:0]  year,
	output logic                        leap
);
	import dad_pkg::*;

	logic [YEAR_W-1:0]         year_q;
	logic [CENT_W-1:0]         cent_q;
	logic [REM_W-1:0]          rem_q;
	logic [1:0]                c4_q;
	logic [YEAR_W+RECIP_W-1:0] prod;
	logic [YEAR_W:0]           times100;
	logic [YEAR_W:0]           rem_full;

	assign prod     = (YEAR_W + RECIP_W)'(year_q) * (YEAR_W + RECIP_W)'(RECIP_100);
	assign times100 = (YEAR_W + 1)'({cent_q, 6'b0}) + (YEAR_W + 1)'({cent_q, 5'b0})
		+ (YEAR_W + 1)'({cent_q, 2'b0});
	assign rem_full = (YEAR_W + 1)'(year_q) - times100;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q <= year_load;
		end else if (cmd.div) begin
			cent_q <= prod[RECIP_SHIFT +: CENT_W];
		end else if (cmd.mod) begin
			rem_q <= rem_full[REM_W-1:0];
			c4_q  <= cent_q[1:0];
		end else if (cmd.inc) begin
			year_q <= year_q + YEAR_W'(1);
			if (rem_q == REM_LAST) begin
				rem_q <= '0;
				c4_q  <= c4_q + 2'd1;
			end else begin
				rem_q <= rem_q + REM_W'(1);
			end
		end else if (cmd.dec) begin
			year_q <= year_q - YEAR_W'(1);
			if (rem_q == '0) begin
				rem_q <= REM_LAST;
				c4_q  <= c4_q - 2'd1;
			end else begin
				rem_q <= rem_q - REM_W'(1);
			end
		end
	end

	assign year = year_q;
	assign leap = (year_q[1:0] == 2'd0 && rem_q != '0) || (rem_q == '0 && c4_q == 2'd0);

endmodule

FILE: rtl/dad_step_unit.sv
// ----------------------------------------------------------------------------
// dad_step_unit
// One month of carry or borrow: a single adder moves the day count by the
// length of the current or the previous month.
// ----------------------------------------------------------------------------
module dad_step_unit (
	input  logic signed [dad_pkg::DACC_W-1:0] day,
	input  logic [dad_pkg::MONTH_W-1:0]       month,
	input  logic                              leap,
	input  logic                              year_max,
	input  logic                              year_min,
	output dad_pkg::step_t                    step
);
	import dad_pkg::*;

	logic [DAY_W-1:0]   len_cur;
	logic [DAY_W-1:0]   len_prev;
	logic [MONTH_W-1:0] month_prev;
	logic [DACC_W-1:0]  len_cur_ext;
	logic [DACC_W-1:0]  operand;
	logic               fwd;
	logic               bwd;

	assign month_prev  = (month == M_JAN) ? M_DEC : month - MONTH_W'(1);
	assign len_cur     = month_len(month, leap);
	assign len_prev    = month_len(month_prev, leap);
	assign len_cur_ext = DACC_W'(len_cur);

	assign fwd = day > $signed(len_cur_ext);
	assign bwd = day[DACC_W-1] || (day == '0);

	assign operand = fwd ? ~len_cur_ext : DACC_W'(len_prev);

	always_comb begin
		step.day_next   = DACC_W'($unsigned(day) + operand + DACC_W'(fwd));
		step.month_next = fwd ? ((month == M_DEC) ? M_JAN : month + MONTH_W'(1)) : month_prev;
		step.yr_inc     = fwd && (month == M_DEC);
		step.yr_dec     = !fwd && bwd && (month == M_JAN);
		step.range_err  = (step.yr_inc && year_max) || (step.yr_dec && year_min);
		step.done       = !fwd && !bwd;
	end

endmodule

FILE: rtl/date_add_days_unit.sv
// ----------------------------------------------------------------------------
// date_add_days_unit
// Adds a signed day offset to a Gregorian date, one month per cycle.
// ----------------------------------------------------------------------------
// One transaction at a time: after a request is taken, the setup states
// S_DIV, S_MOD and S_CHECK derive the leap state of the year and validate
// the date, then the day count is carried or borrowed one month per cycle
// through a single adder. The result waits in an output register; a new
// request is taken once the result has been handed to it. Status is 0
// for a good result, 1 for an invalid start date and 2 for a result year
// outside 0..9999; in both error cases the start date is returned as given.
`include "date_add_days_unit_defines.svh"

module date_add_days_unit (
	input  logic       clk,
	input  logic       arst_n,
	dad_req_if.sink    req,
	dad_rsp_if.source  rsp
);
	import dad_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DIV    = 3'd1;
	localparam logic [2:0] S_MOD    = 3'd2;
	localparam logic [2:0] S_CHECK  = 3'd3;
	localparam logic [2:0] S_RUN    = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]                state_q;
	logic                      out_vld_q;
	logic [YEAR_W-1:0]         yi_q;
	logic [MONTH_W-1:0]        mi_q;
	logic [DAY_W-1:0]          di_q;
	logic [MONTH_W-1:0]        m_q;
	logic signed [DACC_W-1:0]  d_q;
	logic [STATUS_W-1:0]       status_q;
	logic [YEAR_W-1:0]         out_year_q;
	logic [MONTH_W-1:0]        out_month_q;
	logic [DAY_W-1:0]          out_day_q;
	logic [STATUS_W-1:0]       out_status_q;

	yr_cmd_t           yr_cmd;
	logic [YEAR_W-1:0] yr_year;
	logic              yr_leap;
	step_t             step;
	logic              accept;
	logic              bad_date;
	logic              res_ok;
	logic              out_load;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_FINISH) && (!out_vld_q || rsp.ready);
	assign res_ok    = (status_q == ST_OK);

	always_comb begin
		yr_cmd.load = accept;
		yr_cmd.div  = (state_q == S_DIV);
		yr_cmd.mod  = (state_q == S_MOD);
		yr_cmd.inc  = (state_q == S_RUN) && step.yr_inc && !step.range_err;
		yr_cmd.dec  = (state_q == S_RUN) && step.yr_dec && !step.range_err;
	end

	assign bad_date = (yi_q > YEAR_MAX) || (mi_q == '0) || (mi_q > M_DEC) || (di_q == '0)
		|| (di_q > month_len(mi_q, yr_leap));

	dad_year_tracker u_year (
		.clk       (clk),
		.cmd       (yr_cmd),
		.year_load (req.year_in),
		.year      (yr_year),
		.leap      (yr_leap)
	);

	dad_step_unit u_step (
		.day      (d_q),
		.month    (m_q),
		.leap     (yr_leap),
		.year_max (yr_year == YEAR_MAX),
		.year_min (yr_year == '0),
		.step     (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_DIV;
				end
				S_DIV:   state_q <= S_MOD;
				S_MOD:   state_q <= S_CHECK;
				S_CHECK: state_q <= bad_date ? S_FINISH : S_RUN;
				S_RUN: begin
					if (step.range_err || step.done) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			priority if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end else begin
				out_vld_q <= out_vld_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			yi_q <= req.year_in;
			mi_q <= req.month_in;
			di_q <= req.day_in;
			m_q  <= req.month_in;
			d_q  <= $signed({{(DACC_W-DAY_W){1'b0}}, req.day_in})
				+ $signed({{(DACC_W-OFFSET_W){req.offset_days[OFFSET_W-1]}}, req.offset_days});
		end
		if (state_q == S_CHECK) begin
			status_q <= bad_date ? ST_BAD_DATE : ST_OK;
		end
		if (state_q == S_RUN) begin
			if (step.range_err) begin
				status_q <= ST_RANGE;
			end else if (!step.done) begin
				d_q <= $signed(step.day_next);
				m_q <= step.month_next;
			end
		end
		if (out_load) begin
			out_year_q   <= res_ok ? yr_year : yi_q;
			out_month_q  <= res_ok ? m_q : mi_q;
			out_day_q    <= res_ok ? d_q[DAY_W-1:0] : di_q;
			out_status_q <= status_q;
		end
	end

	assign rsp.valid     = out_vld_q;
	assign rsp.year_out  = out_year_q;
	assign rsp.month_out = out_month_q;
	assign rsp.day_out   = out_day_q;
	assign rsp.status    = out_status_q;

	`DAD_ASSERT_NXT(a_busy_after_accept, accept, !req.ready, "ready after accepted transaction")
	`DAD_ASSERT_IMP(a_run_month_valid, state_q == S_RUN, m_q != '0 && m_q <= M_DEC,
		"working month out of range")
	`DAD_ASSERT_IMP(a_ok_day_valid, rsp.valid && rsp.status == ST_OK,
		rsp.day_out != '0 && rsp.month_out != '0 && rsp.month_out <= M_DEC,
		"good result with invalid date")
	`DAD_ASSERT_NXT(a_finish_holds, state_q == S_FINISH && out_vld_q && !rsp.ready,
		state_q == S_FINISH, "result dropped while output stalled")

endmodule
